/* rtl/rmcr_pkg.sv */
// ----------------------------------------------------------------------------
// Rover motor command ramp package
// Shared types, register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rmcr_pkg;

  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [STEP_BITS-1:0]   step_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CfgStraightPeriod = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CfgCruisePeriod   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CfgTurnPeriod     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CfgStrafeTarget   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CfgSlipStart      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CfgRampStep       = 3'd5;

  // Reset values.
  localparam period_t StraightPeriodRst = period_t'(2500);
  localparam period_t CruisePeriodRst   = period_t'(4000);
  localparam period_t TurnPeriodRst     = period_t'(3500);
  localparam period_t StrafeTargetRst   = period_t'(1250);
  localparam period_t SlipStartRst      = period_t'(2500);
  localparam step_t   RampStepRst       = step_t'(5);
  localparam period_t TargetRst         = period_t'(2500);

  // Drive command codes.
  localparam logic [3:0] CmdNoLine      = 4'b0000;
  localparam logic [3:0] CmdStraight    = 4'b0001;
  localparam logic [3:0] CmdRight       = 4'b0011;
  localparam logic [3:0] CmdLeft        = 4'b0110;
  localparam logic [3:0] CmdNorth       = 4'b1000;
  localparam logic [3:0] CmdEast        = 4'b1001;
  localparam logic [3:0] CmdSouth       = 4'b1010;
  localparam logic [3:0] CmdWest        = 4'b1011;

  // Item kinds and channels.
  localparam logic       KindCommand    = 1'b0;
  localparam logic       KindCycle      = 1'b1;
  localparam logic [1:0] ChanFrontBack  = 2'd0;
  localparam logic [1:0] ChanLeft       = 2'd1;
  localparam logic [1:0] ChanRight      = 2'd2;

  // Direction bit positions.
  localparam int unsigned DirLeft  = 0;
  localparam int unsigned DirRight = 1;
  localparam int unsigned DirFront = 2;
  localparam int unsigned DirBack  = 3;

  typedef struct packed {
    logic       kind;
    logic [3:0] command;
    logic [1:0] channel;
  } in_item_t;

  typedef struct packed {
    period_t left_period;
    period_t right_period;
    period_t fore_aft_period;
    logic    left_fwd;
    logic    right_fwd;
    logic    front_fwd;
    logic    rear_fwd;
    logic    ramp_active;
    logic    command_applied;
  } out_item_t;

  typedef struct packed {
    period_t straight_period;
    period_t cruise_period;
    period_t turn_period;
    period_t strafe_target;
    period_t slip_start;
    step_t   ramp_step;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/rmcr_cfg.sv */
// ----------------------------------------------------------------------------
// Rover motor command ramp configuration registers
// Holds the six tuning registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rmcr_cfg
  import rmcr_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [PERIOD_BITS-1:0]  cfg_wdata_i,
  output cfg_t                         cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStraightPeriod: cfg_d.straight_period = cfg_wdata_i;
        CfgCruisePeriod:   cfg_d.cruise_period   = cfg_wdata_i;
        CfgTurnPeriod:     cfg_d.turn_period     = cfg_wdata_i;
        CfgStrafeTarget:   cfg_d.strafe_target   = cfg_wdata_i;
        CfgSlipStart:      cfg_d.slip_start      = cfg_wdata_i;
        CfgRampStep:       cfg_d.ramp_step       = cfg_wdata_i[STEP_BITS-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.straight_period <= StraightPeriodRst;
      cfg_q.cruise_period   <= CruisePeriodRst;
      cfg_q.turn_period     <= TurnPeriodRst;
      cfg_q.strafe_target   <= StrafeTargetRst;
      cfg_q.slip_start      <= SlipStartRst;
      cfg_q.ramp_step       <= RampStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/rmcr_core.sv */
// ----------------------------------------------------------------------------
// Rover motor command ramp core
// Drive state, command decoder and per-channel ramp-down step.
// ----------------------------------------------------------------------------
`default_nettype none

module rmcr_core
  import rmcr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     item_en_i,
  input  wire in_item_t item_i,
  output out_item_t     result_o
);

  logic [3:0] last_cmd_q, last_cmd_d;
  logic       last_valid_q, last_valid_d;
  period_t    left_q, left_d;
  period_t    right_q, right_d;
  period_t    fb_q, fb_d;
  period_t    side_tgt_q, side_tgt_d;
  period_t    fb_tgt_q, fb_tgt_d;
  logic [3:0] dir_q, dir_d;
  logic       ramp_en_q, ramp_en_d;
  logic       applied;

  period_t    ramp_cur;
  period_t    ramp_tgt;
  period_t    ramp_nxt;
  period_t    step_ext;

  // Pick the channel the cycle event refers to, then one compare-subtract.
  always_comb begin
    step_ext = period_t'(cfg_i.ramp_step);
    case (item_i.channel)
      ChanFrontBack: begin
        ramp_cur = fb_q;
        ramp_tgt = fb_tgt_q;
      end
      ChanLeft: begin
        ramp_cur = left_q;
        ramp_tgt = side_tgt_q;
      end
      default: begin
        ramp_cur = right_q;
        ramp_tgt = side_tgt_q;
      end
    endcase
    ramp_nxt = ramp_cur;
    if (ramp_cur > ramp_tgt) begin
      ramp_nxt = (ramp_cur > step_ext) ? ramp_cur - step_ext : '0;
    end
  end

  always_comb begin
    last_cmd_d   = last_cmd_q;
    last_valid_d = last_valid_q;
    left_d       = left_q;
    right_d      = right_q;
    fb_d         = fb_q;
    side_tgt_d   = side_tgt_q;
    fb_tgt_d     = fb_tgt_q;
    dir_d        = dir_q;
    ramp_en_d    = ramp_en_q;
    applied      = 1'b0;

    if (item_i.kind == KindCommand) begin
      if (!last_valid_q || last_cmd_q != item_i.command) begin
        applied      = 1'b1;
        last_cmd_d   = item_i.command;
        last_valid_d = 1'b1;
        ramp_en_d    = item_i.command[3];
        unique case (item_i.command) inside
          CmdNoLine, CmdStraight: begin
            left_d = cfg_i.straight_period;
            right_d = cfg_i.straight_period;
            fb_d = '0;
            dir_d[DirLeft] = 1'b1;
            dir_d[DirRight] = 1'b1;
          end
          CmdRight: begin
            left_d = cfg_i.turn_period;
            right_d = cfg_i.cruise_period;
            fb_d = '0;
            dir_d[DirLeft] = 1'b1;
            dir_d[DirRight] = 1'b1;
          end
          CmdLeft: begin
            left_d = cfg_i.cruise_period;
            right_d = cfg_i.turn_period;
            fb_d = '0;
            dir_d[DirLeft] = 1'b1;
            dir_d[DirRight] = 1'b1;
          end
          CmdNorth, CmdSouth: begin
            dir_d = '0;
            dir_d[DirLeft] = (item_i.command == CmdNorth);
            dir_d[DirRight] = (item_i.command == CmdNorth);
            side_tgt_d = cfg_i.strafe_target;
            left_d = cfg_i.slip_start;
            right_d = cfg_i.slip_start;
            fb_d = '0;
          end
          CmdEast, CmdWest: begin
            dir_d = '0;
            dir_d[DirFront] = (item_i.command == CmdWest);
            dir_d[DirBack] = (item_i.command == CmdWest);
            fb_tgt_d = cfg_i.strafe_target;
            fb_d = cfg_i.slip_start;
            left_d = '0;
            right_d = '0;
          end
          default: begin
            // Unused codes only update the last command and the ramp enable.
          end
        endcase
      end
    end else if (ramp_en_q) begin
      case (item_i.channel)
        ChanFrontBack: fb_d = ramp_nxt;
        ChanLeft:      left_d = ramp_nxt;
        ChanRight:     right_d = ramp_nxt;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q   <= '0;
      last_valid_q <= 1'b0;
      left_q       <= '0;
      right_q      <= '0;
      fb_q         <= '0;
      side_tgt_q   <= TargetRst;
      fb_tgt_q     <= TargetRst;
      dir_q        <= '0;
      ramp_en_q    <= 1'b0;
    end else if (item_en_i) begin
      last_cmd_q   <= last_cmd_d;
      last_valid_q <= last_valid_d;
      left_q       <= left_d;
      right_q      <= right_d;
      fb_q         <= fb_d;
      side_tgt_q   <= side_tgt_d;
      fb_tgt_q     <= fb_tgt_d;
      dir_q        <= dir_d;
      ramp_en_q    <= ramp_en_d;
    end
  end

  always_comb begin
    result_o.left_period     = left_d;
    result_o.right_period    = right_d;
    result_o.fore_aft_period = fb_d;
    result_o.left_fwd        = dir_d[DirLeft];
    result_o.right_fwd       = dir_d[DirRight];
    result_o.front_fwd       = dir_d[DirFront];
    result_o.rear_fwd        = dir_d[DirBack];
    result_o.ramp_active     = ramp_en_d;
    result_o.command_applied = applied;
  end

endmodule

`default_nettype wire

/* rtl/rover_motor_command_ramp.sv */
// ----------------------------------------------------------------------------
// Rover motor command ramp
// Decodes drive commands into stepper periods and directions, and ramps the
// strafe channels down toward their target on each PWM cycle end.
// ----------------------------------------------------------------------------
//   Channel  | Handshake           | Word
//   ---------+---------------------+----------------------------------------
//   input    | in_valid_i/ready_o  | in_item_i: kind, command, channel
//   output   | out_valid_o/ready_i | out_item_o: periods, directions, flags
//   config   | cfg_we_i            | cfg_idx_i, cfg_wdata_i (no wait)
//
// Each word is held in the input register and is then decoded against the
// drive state into the result register, one word per cycle sustained while
// out_ready_i is high. The result register stalls when out_ready_i is low
// and the input register then fills behind it. Reset clears the drive state
// and loads the register defaults; there is no clearing pass.
`default_nettype none

module rover_motor_command_ramp
  import rmcr_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire in_item_t                in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output out_item_t                    out_item_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [PERIOD_BITS-1:0]  cfg_wdata_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, result;
  logic      out_valid_q;
  logic      advance;

  rmcr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // A word moves from the input register to the result register whenever the
  // result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  rmcr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_en_i(advance),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
